@@ sv/bbcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bbcd_pkg;

    // Field and counter widths.
    localparam int unsigned CFG_W  = 32;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned IDX_W  = 2;

    // The quotient of the progress division is always below 128.
    localparam int unsigned QUOT_W = 7;
    localparam int unsigned DIVD_W = CNT_W + QUOT_W;
    localparam int unsigned DEN_W  = CNT_W + QUOT_W - 1;

    localparam int unsigned IN_W  = 8;
    localparam int unsigned OUT_W = 80;

    // Operating modes.
    localparam logic [MODE_W-1:0] MODE_ALIGN     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STANDBY   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ACTIVE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRIGGERED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAULT     = 3'd4;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_ARM     = 3'd1;
    localparam logic [OP_W-1:0] OP_RESET   = 3'd2;
    localparam logic [OP_W-1:0] OP_STANDBY = 3'd3;
    localparam logic [OP_W-1:0] OP_RETRY   = 3'd4;

    // Command status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_MIN_BREAK   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_BREAK   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ALIGN_TICKS = 2'd2;
    localparam logic [IDX_W-1:0] CFG_CLEAR_TICKS = 2'd3;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    // Request to the progress divider.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] num;
        logic [CFG_W-1:0] den;
    } t_div_req;

    // Response from the progress divider.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ sv/bbcd_pct_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Serial restoring divider for (num * 100) / den, one quotient bit per cycle.
// The caller guarantees num < den, so the quotient fits in QUOT_W bits.
module bbcd_pct_div
    import bbcd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_cnt;
    logic [DIVD_W-1:0] r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_q;

    logic [DIVD_W-1:0] w_num_x;
    logic [DIVD_W-1:0] w_scaled;
    logic [DIVD_W-1:0] w_trial;
    logic              w_fit;

    // Times 100 as 64 + 32 + 4.
    assign w_num_x  = {{QUOT_W{1'b0}}, i_req.num};
    assign w_scaled = (w_num_x << 6) + (w_num_x << 5) + (w_num_x << 2);

    // Shared subtract and compare.
    assign w_fit   = r_rem >= {1'b0, r_den};
    assign w_trial = r_rem - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'(QUOT_W - 1);
                r_rem  <= w_scaled;
                r_den  <= {i_req.den, {(QUOT_W-1){1'b0}}};
                r_q    <= '0;
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= w_trial;
                end
                r_q   <= {r_q[QUOT_W-2:0], w_fit};
                r_den <= r_den >> 1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 3'd1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

`default_nettype wire

@@ sv/beam_break_crossing_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Beam-break crossing detector. Each request is one microsecond tick with the
// receiver level, or a command (arm, reset, force standby, retry alignment),
// and yields exactly one result with the mode, trigger and fault pulses, the
// saved trigger time and break length, alignment progress and command status.
// A request first sets the sequencer state and is then loaded into the output
// register, and the input is ready again once the result is loaded. An
// alignment tick that needs a new progress percent passes through the divide
// state first: that percent comes from a serial divider that resolves one
// quotient bit per cycle, and the sequencer takes the quotient when the
// divider reports done. The input is not ready while a request is in work.
// A finished result waits in the output register without holding off the
// next request, but that request is not loaded, and the input stays not
// ready, until the waiting result has been taken.
// The user must write configuration through i_cfg_we, i_cfg_idx and
// i_cfg_data only while the block is idle; the block does not enforce this.
module beam_break_crossing_detector
    import bbcd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Input request.
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [2:0] op, [3] beam_broken, [7:4] zero
    input  wire logic [IN_W-1:0]  i_s_axis_tdata,
    // Result.
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    // [2:0] mode, [3] trigger_pulse, [4] fault_pulse, [36:5] trigger_time,
    // [68:37] break_length, [75:69] align_percent, [76] align_done,
    // [78:77] command_status, [79] zero
    output logic [OUT_W-1:0]      o_m_axis_tdata,
    // Configuration writes.
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SEND
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [CFG_W-1:0] r_cfg_min;
    logic [CFG_W-1:0] r_cfg_max;
    logic [CFG_W-1:0] r_cfg_align;
    logic [CFG_W-1:0] r_cfg_clear;

    // Detector state.
    logic [MODE_W-1:0] r_mode,  n_mode;
    logic              r_pb,    n_pb;
    logic              r_bt,    n_bt;
    logic [CNT_W-1:0]  r_bc,    n_bc;
    logic [TIME_W-1:0] r_bbt,   n_bbt;
    logic [CNT_W-1:0]  r_sc,    n_sc;
    logic              r_sr,    n_sr;
    logic [CNT_W-1:0]  r_cc,    n_cc;
    logic              r_cr,    n_cr;
    logic              r_al,    n_al;
    logic [PCT_W-1:0]  r_pv,    n_pv;
    logic [TIME_W-1:0] r_tt,    n_tt;
    logic [TIME_W-1:0] r_stt,   n_stt;
    logic [CNT_W-1:0]  r_sbl,   n_sbl;
    logic              n_trig;
    logic              n_fault;
    logic [STAT_W-1:0] n_stat;
    logic              n_need_div;

    // Pending pulses and status of the request in work.
    logic              r_trig;
    logic              r_fault;
    logic [STAT_W-1:0] r_stat;

    // Output register.
    logic              r_ovalid;
    logic [OUT_W-1:0]  r_odata;

    logic [OP_W-1:0] w_op;
    logic            w_broken;
    logic            w_accept;
    logic            w_load;
    t_div_req        w_req;
    t_div_rsp        w_rsp;

    assign w_op     = i_s_axis_tdata[OP_W-1:0];
    assign w_broken = i_s_axis_tdata[OP_W];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load   = (r_state == S_SEND) && (!r_ovalid || i_m_axis_tready);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // Next state for one request, evaluated in the cycle it is accepted.
    always_comb begin
        n_mode     = r_mode;
        n_pb       = r_pb;
        n_bt       = r_bt;
        n_bc       = r_bc;
        n_bbt      = r_bbt;
        n_sc       = r_sc;
        n_sr       = r_sr;
        n_cc       = r_cc;
        n_cr       = r_cr;
        n_al       = r_al;
        n_pv       = r_pv;
        n_tt       = r_tt;
        n_stt      = r_stt;
        n_sbl      = r_sbl;
        n_trig     = 1'b0;
        n_fault    = 1'b0;
        n_stat     = ST_OK;
        n_need_div = 1'b0;

        unique case (w_op)
            OP_TICK: begin
                n_tt = r_tt + TIME_W'(1);

                // Break edge starts timing; a timed break counts on.
                if (w_broken && !r_pb) begin
                    n_bt  = 1'b1;
                    n_bc  = '0;
                    n_bbt = n_tt;
                end else if (r_bt) begin
                    n_bc = (r_bc == CNT_MAX) ? r_bc : r_bc + CNT_W'(1);
                end

                // Restore edge of a timed break is judged in active mode.
                if (!w_broken && r_pb && n_bt) begin
                    n_bt  = 1'b0;
                    n_sbl = n_bc;
                    if (n_mode == MODE_ACTIVE && n_bc >= r_cfg_min) begin
                        if (n_bc <= r_cfg_max) begin
                            n_stt  = n_bbt;
                            n_mode = MODE_TRIGGERED;
                            n_trig = 1'b1;
                        end else begin
                            n_mode  = MODE_FAULT;
                            n_cr    = 1'b0;
                            n_fault = 1'b1;
                        end
                    end
                end

                // Mode polling.
                if (n_mode == MODE_ALIGN) begin
                    if (w_broken) begin
                        n_sr = 1'b0;
                        n_sc = '0;
                        n_pv = '0;
                    end else begin
                        if (!n_sr) begin
                            n_sr = 1'b1;
                            n_sc = '0;
                        end else begin
                            n_sc = (n_sc == CNT_MAX) ? n_sc : n_sc + CNT_W'(1);
                        end
                        if (n_sc >= r_cfg_align) begin
                            n_al   = 1'b1;
                            n_pv   = PCT_FULL;
                            n_sr   = 1'b0;
                            n_mode = MODE_STANDBY;
                        end else begin
                            n_need_div = 1'b1;
                        end
                    end
                end else if (n_mode == MODE_ACTIVE) begin
                    if (w_broken && n_bt && n_bc > r_cfg_max) begin
                        n_mode  = MODE_FAULT;
                        n_cr    = 1'b0;
                        n_fault = 1'b1;
                    end
                end else if (n_mode == MODE_FAULT) begin
                    if (w_broken) begin
                        n_cr = 1'b0;
                    end else begin
                        if (!n_cr) begin
                            n_cr = 1'b1;
                            n_cc = '0;
                        end else begin
                            n_cc = (n_cc == CNT_MAX) ? n_cc : n_cc + CNT_W'(1);
                        end
                        if (n_cc >= r_cfg_clear) begin
                            n_cr   = 1'b0;
                            n_sr   = 1'b0;
                            n_sc   = '0;
                            n_pv   = '0;
                            n_mode = MODE_ALIGN;
                        end
                    end
                end

                n_pb = w_broken;
            end
            OP_ARM: begin
                if (r_mode != MODE_STANDBY) begin
                    n_stat = ST_IGNORED;
                end else if (w_broken) begin
                    n_stat = ST_REFUSED;
                end else begin
                    n_bt   = 1'b0;
                    n_mode = MODE_ACTIVE;
                end
            end
            OP_RESET: begin
                if (r_mode != MODE_TRIGGERED) begin
                    n_stat = ST_IGNORED;
                end else begin
                    n_bt = 1'b0;
                    if (w_broken) begin
                        n_mode  = MODE_FAULT;
                        n_cr    = 1'b0;
                        n_fault = 1'b1;
                    end else begin
                        n_mode = MODE_ACTIVE;
                    end
                end
            end
            OP_STANDBY: begin
                n_bt   = 1'b0;
                n_mode = MODE_STANDBY;
            end
            OP_RETRY: begin
                n_al   = 1'b0;
                n_sr   = 1'b0;
                n_sc   = '0;
                n_pv   = '0;
                n_bt   = 1'b0;
                n_mode = MODE_ALIGN;
            end
            default: begin
                n_stat = ST_IGNORED;
            end
        endcase
    end

    // Progress percent request.
    assign w_req.start = w_accept && n_need_div;
    assign w_req.num   = n_sc;
    assign w_req.den   = r_cfg_align;

    bbcd_pct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_min   <= CFG_W'(5000);
            r_cfg_max   <= CFG_W'(500000);
            r_cfg_align <= CFG_W'(2000000);
            r_cfg_clear <= CFG_W'(1000000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_BREAK:   r_cfg_min   <= i_cfg_data;
                CFG_MAX_BREAK:   r_cfg_max   <= i_cfg_data;
                CFG_ALIGN_TICKS: r_cfg_align <= i_cfg_data;
                CFG_CLEAR_TICKS: r_cfg_clear <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer, detector state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_ALIGN;
            r_pb     <= 1'b0;
            r_bt     <= 1'b0;
            r_bc     <= '0;
            r_bbt    <= '0;
            r_sc     <= '0;
            r_sr     <= 1'b0;
            r_cc     <= '0;
            r_cr     <= 1'b0;
            r_al     <= 1'b0;
            r_pv     <= '0;
            r_tt     <= '0;
            r_stt    <= '0;
            r_sbl    <= '0;
            r_trig   <= 1'b0;
            r_fault  <= 1'b0;
            r_stat   <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            // The output is valid from a load until the result is taken.
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode  <= n_mode;
                        r_pb    <= n_pb;
                        r_bt    <= n_bt;
                        r_bc    <= n_bc;
                        r_bbt   <= n_bbt;
                        r_sc    <= n_sc;
                        r_sr    <= n_sr;
                        r_cc    <= n_cc;
                        r_cr    <= n_cr;
                        r_al    <= n_al;
                        r_pv    <= n_pv;
                        r_tt    <= n_tt;
                        r_stt   <= n_stt;
                        r_sbl   <= n_sbl;
                        r_trig  <= n_trig;
                        r_fault <= n_fault;
                        r_stat  <= n_stat;
                        r_state <= n_need_div ? S_DIV : S_SEND;
                    end
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_pv    <= w_rsp.quot;
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    // Load the result once the output register is free.
                    if (w_load) begin
                        r_odata  <= {1'b0, r_stat, r_al, r_pv, r_sbl, r_stt,
                                     r_fault, r_trig, r_mode};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Divider results only arrive while the sequencer waits for them.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // The input is never ready while the divider works.
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.busy |-> !o_s_axis_tready)
        else $error("input ready while divider busy");

    // Progress never exceeds full scale.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv <= PCT_FULL)
        else $error("alignment percent above 100");

    // One request at a time: acceptance closes the input for the next cycle.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("input ready right after acceptance");
`endif

endmodule

`default_nettype wire
